>>> rtl/srl_pkg.sv
// shared types and constants for the stereogram row linker
package srl_pkg;
	localparam int MaxWidth = 1024;
	localparam int ColW = $clog2(MaxWidth);
	localparam int EpochW = 8;

	typedef struct packed {
		logic [7:0] depth;
		logic [7:0] rand_blue;
		logic [7:0] rand_green;
		logic [7:0] rand_red;
		logic       row_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       is_linked;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  eye_separation;
		logic [11:0] eye_distance;
		logic [10:0] row_width;
	} cfg_t;

	typedef enum logic [1:0] {
		CFG_EYE_SEP  = 2'd0,
		CFG_EYE_DIST = 2'd1,
		CFG_ROW_W    = 2'd2
	} cfg_idx_t;

	// one classified pixel handed from the front to the back
	typedef struct packed {
		logic [ColW-1:0] col;
		logic            start;
		logic            link_ok;
		logic [ColW-1:0] lft;
		logic [ColW-1:0] rgt;
		logic [23:0]     rand_col;
	} job_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK,
		BK_READ,
		BK_FETCH,
		BK_OUT
	} bk_state_t;
endpackage

>>> rtl/srl_front.sv
// front end: column tracking and iterative separation divide
module srl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  srl_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  srl_pkg::in_item_t in_data,
	output logic              job_valid,
	input  logic              job_ready,
	output srl_pkg::job_t     job
);
	import srl_pkg::*;

	fr_state_t       state_q, state_nx;
	logic [ColW-1:0] col_q;
	logic            start_q;
	logic [ColW-1:0] x_q;
	logic [7:0]      depth_q;
	logic [23:0]     rand_q;
	logic [17:0]     num_q;
	logic [12:0]     den_q;
	logic [17:0]     quo_q;
	logic [12:0]     rem_q;
	logic [4:0]      cnt_q;
	logic [13:0]     trial;
	logic [ColW-1:0] sep;
	logic [ColW:0]   half;
	logic [ColW+1:0] lft_w, rgt_w;
	logic [11:0]     bound;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FR_IDLE: if (in_valid) state_nx = FR_MUL;
			FR_MUL:  state_nx = FR_DIV;
			FR_DIV:  if (cnt_q == 5'd0) state_nx = FR_PUSH;
			FR_PUSH: if (job_ready) state_nx = FR_IDLE;
			default: state_nx = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == FR_IDLE);
		job_valid = (state_q == FR_PUSH);
	end

	assign trial = {rem_q, num_q[17]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			col_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == FR_IDLE && in_valid) begin
				if (in_data.row_start) col_q <= ColW'(1);
				else col_q <= col_q + 1'b1;
			end
			if (state_q == FR_MUL) cnt_q <= 5'd17;
			if (state_q == FR_DIV && cnt_q != 5'd0) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && in_valid) begin
			x_q     <= in_data.row_start ? '0 : col_q;
			start_q <= in_data.row_start;
			depth_q <= in_data.depth;
			rand_q  <= {in_data.rand_red, in_data.rand_green, in_data.rand_blue};
		end
		if (state_q == FR_MUL) begin
			num_q <= 18'(cfg.eye_separation) * 18'(depth_q);
			den_q <= 13'(depth_q) + 13'(cfg.eye_distance);
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == FR_DIV) begin
			if (!trial[13]) rem_q <= trial[12:0];
			else rem_q <= {rem_q[11:0], num_q[17]};
			quo_q <= {quo_q[16:0], ~trial[13]};
			num_q <= {num_q[16:0], 1'b0};
		end
	end

	// quotient is at most 1023; a zero divisor gives no separation
	assign sep   = (den_q == 13'd0) ? '0 : quo_q[ColW-1:0];
	assign half  = {2'b0, sep[ColW-1:1]};
	assign lft_w = {2'b0, x_q} - {1'b0, half};
	assign rgt_w = lft_w + {2'b0, sep};
	assign bound = (cfg.row_width < 11'(MaxWidth)) ? {1'b0, cfg.row_width} : 12'(MaxWidth);

	always_comb begin
		job.col      = x_q;
		job.start    = start_q;
		job.link_ok  = !lft_w[ColW+1] && (rgt_w < bound);
		job.lft      = lft_w[ColW-1:0];
		job.rgt      = rgt_w[ColW-1:0];
		job.rand_col = rand_q;
	end
endmodule

>>> rtl/srl_queue.sv
// two-entry queue between front and back
module srl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  srl_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output srl_pkg::job_t pop_data
);
	import srl_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

>>> rtl/srl_back.sv
// back end: link and colour memories, output driven from registered state
module srl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  srl_pkg::job_t      job,
	output logic               out_valid,
	input  logic               out_ready,
	output srl_pkg::out_item_t out_data
);
	import srl_pkg::*;

	logic [EpochW+ColW-1:0] link_mem [MaxWidth];
	logic [23:0]            col_mem  [MaxWidth];
	bk_state_t              state_q, state_nx;
	job_t                   j_q;
	logic [EpochW+ColW-1:0] ent_q;
	logic [23:0]            rd_q;
	logic [EpochW-1:0]      epoch_q;
	logic [ColW-1:0]        clr_q;
	logic                   pend_q;
	logic                   wrap;
	logic                   lk;
	logic [23:0]            colour;

	// row number runs out: clear the link memory before the new row
	assign wrap = job.start && (epoch_q == '1);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_q == ColW'(MaxWidth - 1)) state_nx = pend_q ? BK_LOOK : BK_IDLE;
			BK_IDLE:  if (job_valid) state_nx = wrap ? BK_CLEAR : BK_LOOK;
			BK_LOOK:  state_nx = BK_READ;
			BK_READ:  state_nx = BK_FETCH;
			BK_FETCH: state_nx = BK_OUT;
			BK_OUT:   if (out_ready) state_nx = BK_IDLE;
			default:  state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == BK_IDLE);
		out_valid = (state_q == BK_OUT);
	end

	// row number marks entries of the current row; self link counts as unlinked
	assign lk     = (ent_q[EpochW+ColW-1:ColW] == epoch_q) && (ent_q[ColW-1:0] != j_q.col);
	assign colour = lk ? rd_q : j_q.rand_col;

	// link memory: write new link, then read own column
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) j_q <= job;
		if (state_q == BK_CLEAR) link_mem[clr_q] <= '0;
		else if (state_q == BK_LOOK && j_q.link_ok) link_mem[j_q.rgt] <= {epoch_q, j_q.lft};
		if (state_q == BK_READ) ent_q <= link_mem[j_q.col];
	end

	// colour memory read then write own column
	always_ff @(posedge clk) begin
		if (state_q == BK_FETCH) rd_q <= col_mem[ent_q[ColW-1:0]];
		if (state_q == BK_OUT) col_mem[j_q.col] <= colour;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			epoch_q <= EpochW'(1);
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == BK_IDLE && job_valid) begin
				pend_q <= 1'b1;
				if (wrap) epoch_q <= EpochW'(1);
				else if (job.start) epoch_q <= epoch_q + 1'b1;
			end
		end
	end

	always_comb begin
		out_data.out_blue  = colour[7:0];
		out_data.out_green = colour[15:8];
		out_data.out_red   = colour[23:16];
		out_data.is_linked = lk;
	end
endmodule

>>> rtl/stereogram_row_linker.sv
// top level of the stereogram row linker
// one depth pixel with a random colour in, one stereogram pixel out
// in channel: in_valid/in_ready with in_data, row_start marks column zero
// out channel: out_valid/out_ready with out_data, is_linked set when the colour
// was copied from the linked column of the same row
// cfg_we/cfg_idx/cfg_data write eye_separation, eye_distance and row_width
// the front end computes the separation with an 18-step restoring divider and
// takes a new pixel only after it has handed the last one on, which sets the throughput
// the back end steps through its look, read, fetch and out states for each pixel
// a two-entry queue lets the divider run on while the back end waits
// link entries carry an 8-bit row number; after reset and at every 255th row
// start the back end clears the whole link memory while the queue fills
// reset clears the column count and sets the row number to one
// a stalled receiver holds the back end, then fills the queue, then the front
module stereogram_row_linker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  srl_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output srl_pkg::out_item_t out_data
);
	import srl_pkg::*;

	cfg_t cfg_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	job_t fj, bj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eye_separation <= 10'd168;
			cfg_q.eye_distance   <= 12'd840;
			cfg_q.row_width      <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_EYE_SEP:  cfg_q.eye_separation <= cfg_data[9:0];
				CFG_EYE_DIST: cfg_q.eye_distance   <= cfg_data;
				CFG_ROW_W:    cfg_q.row_width      <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	srl_front u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_ready, .in_data,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	srl_queue u_queue (
		.clk, .arst_n,
		.push_valid(fj_valid), .push_ready(fj_ready), .push_data(fj),
		.pop_valid(bj_valid), .pop_ready(bj_ready), .pop_data(bj)
	);

	srl_back u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid, .out_ready, .out_data
	);
endmodule
